// ----- src/fsas_pkg.sv -----
// ----------------------------------------------------------------------------
// fsas_pkg - shared types, constants and sine table builder
// Command word between controller and datapath, state codes, and the
// integer quarter-wave series used to fill the Q15 sine ROM.
// ----------------------------------------------------------------------------
package fsas_pkg;

	localparam logic [63:0] PIO2_Q30  = 64'd1686629713;
	localparam int          OUT_MAX   = 8388607;
	localparam int          OUT_MIN   = -8388608;
	localparam logic [6:0]  HIU_RESET = 7'd50;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MEAN_INIT, ST_MEAN_RUN, ST_MEAN_DRAIN, ST_MEAN_END,
		ST_HARM_INIT, ST_HARM_RUN, ST_HARM_DRAIN, ST_HARM_END,
		ST_EVAL_RUN, ST_EVAL_DRAIN, ST_EVAL_END
	} state_t;

	typedef enum logic [1:0] {OP_MEAN, OP_HARM, OP_EVAL} op_t;

	typedef struct packed {
		op_t  op;
		logic tap;        // issue one sample/harmonic read
		logic acc_clr;
		logic mean_wr;
		logic harm_init;
		logic harm_first;
		logic n_odd;
		logic coef_wr;
		logic coef_zero;
		logic load_wr;
		logic eval_init;
		logic out_load;
	} cmd_t;

	// (t*x)>>30 in Q30
	function automatic logic [63:0] q30_mul(input logic [63:0] t, input logic [63:0] x);
		logic [63:0] p;
		p = t * x;
		return p >> 30;
	endfunction

	// Q15 sine of r/2^lgq * pi/2 by Taylor series to the 17th power
	function automatic logic signed [15:0] quarter_sin(input logic [63:0] r,
			input int unsigned lgq);
		logic [63:0]        x;
		logic [63:0]        t;
		logic signed [63:0] s;
		logic [63:0]        v;
		x = (r * PIO2_Q30) >> lgq;
		t = x;
		s = $signed(x);
		t = q30_mul(q30_mul(t, x), x) / 64'd6;   s = s - $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd20;  s = s + $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd42;  s = s - $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd72;  s = s + $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd110; s = s - $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd156; s = s + $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd210; s = s - $signed(t);
		t = q30_mul(q30_mul(t, x), x) / 64'd272; s = s + $signed(t);
		if (s < 0)
			s = 0;
		if (s > 64'sd1073741824)
			s = 64'sd1073741824;
		v = ($unsigned(s) * 64'd32767 + 64'd536870912) >> 30;
		return $signed(v[15:0]);
	endfunction

	// entry i of a 2^lgd sine table, quarter wave mirrored
	function automatic logic signed [15:0] sin_entry(input int unsigned i,
			input int unsigned lgd);
		int unsigned        qq;
		int unsigned        q;
		int unsigned        r;
		int unsigned        arg;
		logic signed [15:0] v;
		qq  = lgd - 2;
		q   = i >> qq;
		r   = i & ((1 << qq) - 1);
		arg = ((q & 1) != 0) ? (1 << qq) - r : r;
		v   = quarter_sin(64'(arg), qq);
		return ((q & 2) != 0) ? -v : v;
	endfunction

endpackage

// ----- src/fsas_ifaces.sv -----
// ----------------------------------------------------------------------------
// fsas interfaces - valid/ready channels for input and result words
// ----------------------------------------------------------------------------
interface fsas_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [9:0]         sample_index;
	logic signed [15:0] sample_value;
	logic               last_sample;
	logic [15:0]        eval_phase;
	modport source (output valid, mode, sample_index, sample_value, last_sample,
		eval_phase, input ready);
	modport sink (input valid, mode, sample_index, sample_value, last_sample,
		eval_phase, output ready);
endinterface

interface fsas_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] series_value;
	logic               saturated;
	modport source (output valid, series_value, saturated, input ready);
	modport sink (input valid, series_value, saturated, output ready);
endinterface

// ----- src/fsas_ctrl.sv -----
// ----------------------------------------------------------------------------
// fsas_ctrl - sequencer
// Walks the mean pass, the harmonic passes and the evaluation loop, issuing
// the reads, and owns the harmonics register and the result-valid flag.
// ----------------------------------------------------------------------------
module fsas_ctrl import fsas_pkg::*; #(
	parameter int NUM_SAMPLES   = 1024,
	parameter int MAX_HARMONICS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_mode,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 cfg_we,
	input  logic [6:0]           cfg_wdata,
	output cmd_t                 cmd,
	output logic [$clog2(NUM_SAMPLES)-1:0] k_addr,
	output logic [((MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1)-1:0] c_addr
);
	localparam int LG_N = $clog2(NUM_SAMPLES);
	localparam int NH_W = $clog2(MAX_HARMONICS + 1);
	localparam int CA_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam logic [LG_N-1:0] K_LAST = LG_N'(NUM_SAMPLES - 1);
	localparam logic [NH_W-1:0] N_MAX  = NH_W'(MAX_HARMONICS);

	state_t          state_q, state_d;
	logic [LG_N-1:0] k_q;
	logic [NH_W-1:0] n_q;
	logic [NH_W-1:0] h_eff;
	logic [NH_W-1:0] n_m1;
	logic [6:0]      hiu_q;
	logic            tog_q, dcnt_q, out_vld_q;
	logic            accept, out_free;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_vld_q || out_ready;
	assign h_eff    = (int'(hiu_q) > MAX_HARMONICS) ? N_MAX : NH_W'(hiu_q);
	assign n_m1     = n_q - 1'b1;
	assign k_addr   = k_q;
	assign c_addr   = CA_W'(n_m1);
	assign out_valid = out_vld_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_mode)
					state_d = (h_eff == '0) ? ST_EVAL_END : ST_EVAL_RUN;
				else if (accept && in_last)
					state_d = ST_MEAN_INIT;
			end
			ST_MEAN_INIT: state_d = ST_MEAN_RUN;
			ST_MEAN_RUN: begin
				if (tog_q && k_q == K_LAST)
					state_d = ST_MEAN_DRAIN;
			end
			ST_MEAN_DRAIN: if (dcnt_q) state_d = ST_MEAN_END;
			ST_MEAN_END:   state_d = ST_HARM_INIT;
			ST_HARM_INIT:  state_d = (n_q <= h_eff) ? ST_HARM_RUN : ST_HARM_END;
			ST_HARM_RUN: begin
				if (tog_q && k_q == K_LAST)
					state_d = ST_HARM_DRAIN;
			end
			ST_HARM_DRAIN: if (dcnt_q) state_d = ST_HARM_END;
			ST_HARM_END:   state_d = (n_q == N_MAX) ? ST_IDLE : ST_HARM_INIT;
			ST_EVAL_RUN: begin
				if (tog_q && n_q == h_eff)
					state_d = ST_EVAL_DRAIN;
			end
			ST_EVAL_DRAIN: if (dcnt_q) state_d = ST_EVAL_END;
			ST_EVAL_END:   if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.op = OP_EVAL;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_wr   = accept && !in_mode;
				cmd.eval_init = accept && in_mode;
			end
			ST_MEAN_INIT: begin
				cmd.op = OP_MEAN;
				cmd.acc_clr = 1'b1;
			end
			ST_MEAN_RUN: begin
				cmd.op  = OP_MEAN;
				cmd.tap = !tog_q;
			end
			ST_MEAN_DRAIN: cmd.op = OP_MEAN;
			ST_MEAN_END: begin
				cmd.op = OP_MEAN;
				cmd.mean_wr = 1'b1;
			end
			ST_HARM_INIT: begin
				cmd.op = OP_HARM;
				cmd.acc_clr    = 1'b1;
				cmd.harm_init  = (n_q <= h_eff);
				cmd.harm_first = (n_q == NH_W'(1));
				cmd.n_odd      = n_q[0];
			end
			ST_HARM_RUN: begin
				cmd.op  = OP_HARM;
				cmd.tap = !tog_q;
			end
			ST_HARM_DRAIN: cmd.op = OP_HARM;
			ST_HARM_END: begin
				cmd.op = OP_HARM;
				cmd.coef_wr   = 1'b1;
				cmd.coef_zero = (n_q > h_eff);
			end
			ST_EVAL_RUN:   cmd.tap = !tog_q;
			ST_EVAL_DRAIN: cmd.tap = 1'b0;
			ST_EVAL_END:   cmd.out_load = out_free;
			default:       cmd = '0;
		endcase
	end

	// state, counters, harmonics register, result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			n_q       <= '0;
			tog_q     <= 1'b0;
			dcnt_q    <= 1'b0;
			hiu_q     <= HIU_RESET;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				hiu_q <= cfg_wdata;
			if (cmd.out_load)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					tog_q <= 1'b0;
					n_q   <= NH_W'(1);
				end
				ST_MEAN_INIT, ST_HARM_INIT: begin
					k_q   <= '0;
					tog_q <= 1'b0;
				end
				ST_MEAN_RUN, ST_HARM_RUN: begin
					tog_q <= !tog_q;
					if (tog_q)
						k_q <= k_q + 1'b1;
				end
				ST_EVAL_RUN: begin
					tog_q <= !tog_q;
					if (tog_q && n_q != h_eff)
						n_q <= n_q + 1'b1;
				end
				ST_MEAN_DRAIN, ST_HARM_DRAIN, ST_EVAL_DRAIN: dcnt_q <= !dcnt_q;
				ST_MEAN_END: n_q <= NH_W'(1);
				ST_HARM_END: n_q <= n_q + 1'b1;
				default: tog_q <= tog_q;
			endcase
		end
	end

endmodule

// ----- src/fsas_dp.sv -----
// ----------------------------------------------------------------------------
// fsas_dp - datapath
// Sample store, sine ROM with two read ports, coefficient memory, phase
// accumulator, one shared signed multiplier and the accumulators.
// ----------------------------------------------------------------------------
module fsas_dp import fsas_pkg::*; #(
	parameter int NUM_SAMPLES      = 1024,
	parameter int MAX_HARMONICS    = 64,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [$clog2(NUM_SAMPLES)-1:0] k_addr,
	input  logic [((MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1)-1:0] c_addr,
	input  logic [9:0]          sample_index,
	input  logic signed [15:0]  sample_value,
	input  logic [15:0]         eval_phase,
	output logic signed [23:0]  series_value,
	output logic                saturated
);
	localparam int LG_N  = $clog2(NUM_SAMPLES);
	localparam int LG_T  = $clog2(SINE_TABLE_DEPTH);
	localparam int ACC_W = 34 + LG_N;
	localparam logic [15:0] STEP = 16'(1 << (16 - LG_N));
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

	// sine ROM, built at elaboration
	logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];
	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
		assign sin_rom[gi] = sin_entry(gi, LG_T);
	end

	logic signed [15:0] store_mem [NUM_SAMPLES];
	logic [35:0]        coef_mem [MAX_HARMONICS];
	logic [MAX_HARMONICS-1:0] cvld_q;

	logic [LG_N+9:0]    idx_ext;
	logic               in_range;
	logic [15:0]        ph_q, inc_q, cph;
	logic signed [15:0] samp_rd_q, cos_rd_q, sin_rd_q;
	logic [35:0]        coef_rd_q;
	logic               cvld_rd_q;
	logic               tap_s1, tap_s2, pv_s3, psin_s3;
	logic signed [17:0] mx, ca, cb;
	logic signed [15:0] my;
	logic signed [33:0] prod_s3;
	logic signed [ACC_W-1:0] acc_a_q, acc_b_q, a_sh, b_sh, m_sh;
	logic signed [15:0] mean_q;

	assign idx_ext  = (LG_N + 10)'(sample_index);
	assign in_range = (int'(idx_ext) < NUM_SAMPLES);
	assign cph      = ph_q + 16'd16384;

	// sample store
	always_ff @(posedge clk) begin
		if (cmd.load_wr && in_range)
			store_mem[idx_ext[LG_N-1:0]] <= sample_value;
	end

	// registered reads, taken only on a tap
	always_ff @(posedge clk) begin
		if (cmd.tap) begin
			samp_rd_q <= store_mem[k_addr];
			cos_rd_q  <= sin_rom[cph[15 -: LG_T]];
			sin_rd_q  <= sin_rom[ph_q[15 -: LG_T]];
			coef_rd_q <= coef_mem[c_addr];
			cvld_rd_q <= cvld_q[c_addr];
		end
	end

	// coefficient memory
	assign a_sh = acc_a_q >>> (14 + LG_N);
	assign b_sh = acc_b_q >>> (14 + LG_N);
	assign m_sh = acc_a_q >>> LG_N;
	always_ff @(posedge clk) begin
		if (cmd.coef_wr)
			coef_mem[c_addr] <= cmd.coef_zero ? 36'd0 : {a_sh[17:0], b_sh[17:0]};
	end

	// valid bits and mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q <= '0;
			mean_q <= '0;
		end else begin
			if (cmd.coef_wr)
				cvld_q[c_addr] <= 1'b1;
			if (cmd.mean_wr)
				mean_q <= m_sh[15:0];
		end
	end

	// phase accumulator
	always_ff @(posedge clk) begin
		if (cmd.eval_init) begin
			ph_q  <= eval_phase;
			inc_q <= eval_phase;
		end else if (cmd.harm_init) begin
			ph_q  <= {cmd.n_odd, 15'd0};
			inc_q <= cmd.harm_first ? STEP : inc_q + STEP;
		end else if (cmd.tap) begin
			ph_q <= ph_q + inc_q;
		end
	end

	// pipeline tags: cosine product then sine product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1  <= 1'b0;
			tap_s2  <= 1'b0;
			pv_s3   <= 1'b0;
			psin_s3 <= 1'b0;
		end else begin
			tap_s1  <= cmd.tap;
			tap_s2  <= tap_s1;
			pv_s3   <= (tap_s1 || tap_s2) && (cmd.op != OP_MEAN);
			psin_s3 <= tap_s2;
		end
	end

	// shared multiplier
	assign ca = cvld_rd_q ? $signed(coef_rd_q[35:18]) : 18'sd0;
	assign cb = cvld_rd_q ? $signed(coef_rd_q[17:0]) : 18'sd0;
	always_comb begin
		if (cmd.op == OP_EVAL)
			mx = tap_s2 ? cb : ca;
		else
			mx = 18'(samp_rd_q);
		my = tap_s2 ? sin_rd_q : cos_rd_q;
	end
	always_ff @(posedge clk) begin
		prod_s3 <= mx * my;
	end

	// accumulators
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (cmd.eval_init) begin
			acc_a_q <= ACC_W'(mean_q);
		end else if (cmd.op == OP_MEAN && tap_s1) begin
			acc_a_q <= acc_a_q + ACC_W'(samp_rd_q);
		end else if (pv_s3) begin
			if (cmd.op == OP_EVAL)
				acc_a_q <= acc_a_q + ACC_W'(prod_s3 >>> 15);
			else if (psin_s3)
				acc_b_q <= acc_b_q + ACC_W'(prod_s3);
			else
				acc_a_q <= acc_a_q + ACC_W'(prod_s3);
		end
	end

	// result register with clamp
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (acc_a_q > SAT_HI) begin
				series_value <= 24'(OUT_MAX);
				saturated    <= 1'b1;
			end else if (acc_a_q < SAT_LO) begin
				series_value <= 24'(OUT_MIN);
				saturated    <= 1'b1;
			end else begin
				series_value <= acc_a_q[23:0];
				saturated    <= 1'b0;
			end
		end
	end

endmodule

// ----- src/fourier_series_analyse_synthesise.sv -----
// ----------------------------------------------------------------------------
// fourier_series_analyse_synthesise - Fourier coefficients and partial sum
//
//  channel  dir  word
//  in_ch    in   mode, sample_index, sample_value, last_sample, eval_phase
//  out_ch   out  series_value, saturated (one per evaluate word)
//  cfg      in   harmonics_in_use, 7 bits
//
// A plain load leaves the block ready. A load marked last runs the analysis:
// a pass for the mean, then a pass per active harmonic, in which the single
// multiplier does a cosine and a sine product per sample; unused ones are zeroed.
// An evaluate word sums the mean and the H active harmonics.
// Reset is asynchronous; coefficients read as zero until computed.
// A waiting result holds the sequencer only when the next one is ready.
// ----------------------------------------------------------------------------
module fourier_series_analyse_synthesise import fsas_pkg::*; #(
	parameter int NUM_SAMPLES      = 1024,
	parameter int MAX_HARMONICS    = 64,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	fsas_in_if.sink     in_ch,
	fsas_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);
	localparam int LG_N = $clog2(NUM_SAMPLES);
	localparam int CA_W = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

	cmd_t            cmd;
	logic [LG_N-1:0] k_addr;
	logic [CA_W-1:0] c_addr;

	fsas_ctrl #(
		.NUM_SAMPLES  (NUM_SAMPLES),
		.MAX_HARMONICS(MAX_HARMONICS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.in_mode  (in_ch.mode),
		.in_last  (in_ch.last_sample),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.k_addr   (k_addr),
		.c_addr   (c_addr)
	);

	fsas_dp #(
		.NUM_SAMPLES     (NUM_SAMPLES),
		.MAX_HARMONICS   (MAX_HARMONICS),
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.k_addr      (k_addr),
		.c_addr      (c_addr),
		.sample_index(in_ch.sample_index),
		.sample_value(in_ch.sample_value),
		.eval_phase  (in_ch.eval_phase),
		.series_value(out_ch.series_value),
		.saturated   (out_ch.saturated)
	);

endmodule

// ----- src/fsas_checker.sv -----
// ----------------------------------------------------------------------------
// fsas_checker - port-level checks
// Stalled result holds; evaluation and analysis make the block busy; a
// plain load leaves it ready.
// ----------------------------------------------------------------------------
module fsas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_mode,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] out_value,
	input logic        out_sat
);
	// stalled result word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_sat))
		else $error("result word changed while stalled");

	// an evaluate word occupies the sequencer
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_mode |=> !in_ready)
		else $error("ready during evaluation");

	// a last load starts the analysis
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_mode && in_last |=> !in_ready)
		else $error("ready during analysis");

	// a plain load leaves the input ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_mode && !in_last |=> in_ready)
		else $error("not ready after plain load");

endmodule

bind fourier_series_analyse_synthesise fsas_checker u_fsas_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.in_mode  (in_ch.mode),
	.in_last  (in_ch.last_sample),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_value(out_ch.series_value),
	.out_sat  (out_ch.saturated)
);

// ----- bench/fsas_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsas_scoreboard - predictor and scoreboard for the Fourier series block
// Watches the input, result and register ports, keeps its own sample store,
// coefficients and sine ROM, and compares every result word in order.
// ----------------------------------------------------------------------------
module fsas_scoreboard import fsas_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	fsas_in_if    in_ch,
	fsas_out_if   out_ch,
	input  logic  cfg_we,
	input  logic [6:0] cfg_wdata,
	output int    errors,
	output int    pending,
	output int    checked
);

	localparam int N_SMP  = 1024;
	localparam int N_HARM = 64;
	localparam int ROM_SZ = 1024;

	typedef struct {
		logic signed [23:0] value;
		logic               sat;
	} series_t;

	int          sine_rom [ROM_SZ];
	int          samples  [N_SMP];
	int          cos_coef [N_HARM];
	int          sin_coef [N_HARM];
	int          mean_val;
	logic [6:0]  harm_reg;
	series_t     series_q [$];

	// Q15 sine over a quarter wave of 256 steps, odd Taylor terms in Q30
	function automatic int quarter_wave(int unsigned r);
		longint unsigned x;
		longint unsigned t;
		longint          s;
		x = (64'(r) * PIO2_Q30) / 64'd256;
		t = x;
		s = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				s = s - longint'(t);
			else
				s = s + longint'(t);
		end
		if (s < 0)
			s = 0;
		if (s > 64'sd1073741824)
			s = 64'sd1073741824;
		return int'((longint'(s) * 64'sd32767 + 64'sd536870912) >>> 30);
	endfunction

	function automatic int rom_sine(int unsigned ph);
		return sine_rom[(ph & 16'hFFFF) >> 6];
	endfunction

	function automatic int rom_cosine(int unsigned ph);
		return rom_sine(ph + 16384);
	endfunction

	function automatic int active_harm();
		return (harm_reg > N_HARM) ? N_HARM : int'(harm_reg);
	endfunction

	// rectangle-rule coefficients from the whole sample store
	function automatic void run_analysis();
		longint      tot;
		longint      ca;
		longint      cb;
		int unsigned th;
		int unsigned ph;
		int          h;
		h   = active_harm();
		tot = 0;
		for (int k = 0; k < N_SMP; k++)
			tot += samples[k];
		mean_val = int'(tot >>> 10);
		for (int n = 1; n <= N_HARM; n++) begin
			ca = 0;
			cb = 0;
			if (n <= h) begin
				for (int k = 0; k < N_SMP; k++) begin
					th = (k * 64 - 32768) & 16'hFFFF;
					ph = (n * th) & 16'hFFFF;
					ca += longint'(samples[k]) * rom_cosine(ph);
					cb += longint'(samples[k]) * rom_sine(ph);
				end
				ca = ca >>> 24;
				cb = cb >>> 24;
			end
			cos_coef[n - 1] = int'(ca);
			sin_coef[n - 1] = int'(cb);
		end
	endfunction

	// mean plus harmonics 1..H at one phase, clamped to 24 bits
	function automatic series_t partial_sum(int unsigned phase);
		series_t     r;
		longint      acc;
		int unsigned ph;
		acc   = mean_val;
		r.sat = 1'b0;
		for (int n = 1; n <= active_harm(); n++) begin
			ph  = (n * phase) & 16'hFFFF;
			acc += (longint'(cos_coef[n - 1]) * rom_cosine(ph)) >>> 15;
			acc += (longint'(sin_coef[n - 1]) * rom_sine(ph)) >>> 15;
		end
		if (acc > OUT_MAX) begin
			acc   = OUT_MAX;
			r.sat = 1'b1;
		end else if (acc < OUT_MIN) begin
			acc   = OUT_MIN;
			r.sat = 1'b1;
		end
		r.value = acc[23:0];
		return r;
	endfunction

	// ROM and predictor state as after reset
	initial begin
		int q;
		int r;
		int v;
		for (int i = 0; i < ROM_SZ; i++) begin
			q = i / 256;
			r = i % 256;
			v = (q % 2 == 1) ? quarter_wave(256 - r) : quarter_wave(r);
			sine_rom[i] = (q >= 2) ? -v : v;
		end
		foreach (samples[i])
			samples[i] = 0;
		foreach (cos_coef[i]) begin
			cos_coef[i] = 0;
			sin_coef[i] = 0;
		end
		mean_val = 0;
		harm_reg = HIU_RESET;
		errors   = 0;
		pending  = 0;
		checked  = 0;
	end

	// watch register, input and result ports
	always @(posedge clk) begin
		series_t got;
		series_t want;
		if (arst_n) begin
			if (cfg_we)
				harm_reg = cfg_wdata;
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.mode == 1'b0) begin
					samples[in_ch.sample_index] = int'(in_ch.sample_value);
					if (in_ch.last_sample)
						run_analysis();
				end else begin
					series_q.push_back(partial_sum(in_ch.eval_phase));
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				got.value = out_ch.series_value;
				got.sat   = out_ch.saturated;
				if (series_q.size() == 0) begin
					errors++;
					$display("%0t: result word with none expected: value %0d sat %0b",
						$time, got.value, got.sat);
				end else begin
					want = series_q.pop_front();
					checked++;
					if (got.value !== want.value) begin
						errors++;
						$display("%0t: series_value expected %0d actual %0d",
							$time, want.value, got.value);
					end
					if (got.sat !== want.sat) begin
						errors++;
						$display("%0t: saturated expected %0b actual %0b",
							$time, want.sat, got.sat);
					end
				end
			end
		end
		pending = series_q.size();
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - stimulus and verdict for the Fourier series block
// Loads sample sets, runs the analysis under several harmonic counts and
// evaluates the partial sum at directed and random phases, with random
// gaps on both sides and one long hold-off of the result port.
// ----------------------------------------------------------------------------
module testbench;
	import fsas_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	int         errors;
	int         pending;
	int         checked;
	longint     cycles;
	int         n_loads;
	int         n_evals;
	bit         calm;
	bit         hold_req;

	fsas_in_if  in_ch ();
	fsas_out_if out_ch ();

	fourier_series_analyse_synthesise uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	fsas_scoreboard chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// result port: random stalls, one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_req = 1'b0;
				out_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// one input word; returns at the falling edge after acceptance
	task automatic send_word(bit m, logic [9:0] idx, logic signed [15:0] val,
			bit last, logic [15:0] ph);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.mode         <= m;
		in_ch.sample_index <= idx;
		in_ch.sample_value <= val;
		in_ch.last_sample  <= last;
		in_ch.eval_phase   <= ph;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (m)
			n_evals++;
		else
			n_loads++;
	endtask

	// load word with random noise in the evaluate-only field
	task automatic load(logic [9:0] idx, logic signed [15:0] val, bit last);
		send_word(1'b0, idx, val, last, 16'($urandom));
	endtask

	// evaluate word with random noise in the load-only fields
	task automatic evaluate(logic [15:0] ph);
		send_word(1'b1, 10'($urandom), 16'($urandom), 1'($urandom), ph);
	endtask

	// drain results, then let the block settle before a register write
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_harm(logic [6:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// rewrite a few random samples, the last word starting the analysis
	task automatic reload(int cnt, bit extremes);
		logic signed [15:0] v;
		for (int i = 0; i < cnt; i++) begin
			if (extremes)
				v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			else
				v = 16'($urandom);
			load(10'($urandom), v, i == cnt - 1);
		end
	endtask

	task automatic random_evals(int cnt);
		repeat (cnt)
			evaluate(16'($urandom));
	endtask

	initial begin
		logic signed [15:0] v;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		in_ch.valid        = 1'b0;
		in_ch.mode         = 1'b0;
		in_ch.sample_index = '0;
		in_ch.sample_value = '0;
		in_ch.last_sample  = 1'b0;
		in_ch.eval_phase   = '0;
		calm               = 1'b0;
		hold_req           = 1'b0;
		n_loads            = 0;
		n_evals            = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// coefficients still zero, reset harmonic count
		evaluate(16'h0000);
		evaluate(16'hFFFF);
		evaluate(16'h4000);
		settle();

		// full period, all 64 harmonics; field extremes first
		write_harm(7'd64);
		for (int k = 0; k < 1024; k++) begin
			case (k)
				0:       v = 16'sh8000;
				1:       v = 16'sh7FFF;
				2:       v = 16'sh0000;
				3:       v = -16'sd1;
				default: v = 16'($urandom);
			endcase
			load(10'(k), v, k == 1023);
		end
		evaluate(16'h0000);
		evaluate(16'hFFFF);
		evaluate(16'h8000);
		evaluate(16'h4000);
		evaluate(16'h0001);
		// long hold-off on results while words keep coming
		hold_req = 1'b1;
		random_evals(30);
		settle();

		// mean only
		write_harm(7'd0);
		reload(4, 1'b0);
		random_evals(8);
		settle();

		// single harmonic
		write_harm(7'd1);
		reload(4, 1'b0);
		random_evals(8);
		settle();

		// above the maximum acts as the maximum; loads and evaluates mixed
		write_harm(7'd127);
		for (int i = 0; i < 20; i++) begin
			if ($urandom_range(0, 2) == 0)
				load(10'($urandom), $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000, 1'b0);
			else
				evaluate(16'($urandom));
		end
		reload(8, 1'b1);
		random_evals(12);
		settle();

		// fewer harmonics summed than were computed
		write_harm(7'd17);
		random_evals(8);

		// closing stretch without gaps
		calm = 1'b1;
		random_evals(20);
		settle();

		$display("Covered %0d loads and %0d evaluations, %0d results compared,",
			n_loads, n_evals, checked);
		$display("harmonic counts 50, 64, 0, 1, 127 and 17, one long result stall.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
